FILE: rtl/sabd_pkg.sv
// Package with the types, constants and helper functions of the sensor average bar display.
`timescale 1ns / 1ps
package sabd_pkg;

   // Number of LED bar rows sent per reading, and the width of a row number.
   localparam int ROWS  = 10;
   localparam int ROW_W = 4;
   localparam int AVG_W = 16;

   // Reset values and limits of the running averages.
   localparam logic [AVG_W-1:0] TEMP_AVG_RESET  = 16'(25 << 6);
   localparam logic [AVG_W-1:0] LIGHT_AVG_RESET = 16'd0;
   localparam logic [AVG_W:0]   LIGHT_AVG_LIMIT = 17'(1600 << 4);
   localparam logic [AVG_W-1:0] LIGHT_AVG_MAX   = 16'((1600 << 4) - 1);

   // Unit glyph codes on the display.
   localparam logic [4:0] GLYPH_CELSIUS = 5'h14;
   localparam logic [4:0] GLYPH_LUX     = 5'h15;

   // Temperature bar: LEDs from this index on get thresholds shifted down, partly below zero.
   localparam logic [6:0]       TEMP_WRAP_ID     = 7'd50;
   localparam logic [AVG_W-1:0] TEMP_WRAP_OFFSET = 16'(128 * 60);

   // Last row number, sized to the row field.
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // Updated average handed from the update stage to the row emitter.
   typedef struct packed {
      logic [AVG_W-1:0] avg;
      logic             light;
   } sabd_avg_type;

   // Display digits that stay the same for all rows of one reading.
   typedef struct packed {
      logic [3:0] first;
      logic [3:0] second;
      logic [3:0] third;
   } sabd_digits_type;

   // Threshold of one LED: 320 per step for light, 128 per step for
   // temperature with the upper LEDs shifted down by 60 steps.
   function automatic logic [AVG_W-1:0] bar_threshold(input logic light_sel,
                                                      input logic [6:0] id);
      logic [AVG_W-1:0] id_ext;
      logic [AVG_W-1:0] th;
      id_ext = {9'd0, id};
      if (light_sel) begin
         th = (id_ext << 8) + (id_ext << 6);
      end else if (id < TEMP_WRAP_ID) begin
         th = id_ext << 7;
      end else begin
         th = (id_ext << 7) - TEMP_WRAP_OFFSET;
      end
      return th;
   endfunction

endpackage

FILE: rtl/sabd_req_if.sv
// Channel interfaces for readings and for bar row results.
`timescale 1ns / 1ps
interface sabd_req_if;
   logic        valid;
   logic        ready;
   logic        light_mode;
   logic [15:0] reading;

   modport source (output valid, output light_mode, output reading, input ready);
   modport sink   (input valid, input light_mode, input reading, output ready);
endinterface

interface sabd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  row_index;
   logic [7:0]  row_bits;
   logic [3:0]  digit_first;
   logic [3:0]  digit_second;
   logic [3:0]  digit_third;
   logic [4:0]  digit_unit;
   logic        colon_on;
   logic [15:0] average_value;
   logic        last_row;

   modport source (output valid, output row_index, output row_bits, output digit_first,
                   output digit_second, output digit_third, output digit_unit,
                   output colon_on, output average_value, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input row_bits, input digit_first,
                   input digit_second, input digit_third, input digit_unit,
                   input colon_on, input average_value, input last_row,
                   output ready);
endinterface

FILE: rtl/sabd_update.sv
// Running average update for the temperature and light readings.
`timescale 1ns / 1ps
module sabd_update (
   input  logic                  clock,
   input  logic                  reset,
   sabd_req_if.sink              req_ch,
   output logic                  upd_valid,
   input  logic                  upd_ready,
   output sabd_pkg::sabd_avg_type upd_data
);
   import sabd_pkg::*;

   logic [AVG_W-1:0] temp_avg_ff, temp_avg_in;
   logic [AVG_W-1:0] light_avg_ff, light_avg_in;
   logic             valid_ff, valid_in;
   sabd_avg_type     data_ff, data_in;
   logic             accept;
   logic [19:0]      temp_sum;
   logic [AVG_W:0]   light_sum;
   logic [AVG_W-1:0] temp_new;
   logic [AVG_W-1:0] light_new;

   // The holding register frees up when the row emitter takes its item.
   assign req_ch.ready = !valid_ff || upd_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Temperature: (avg*7 + x) / 8; light: avg/8*7 + x/8, clamped.
   always_comb begin
      temp_sum  = ({4'd0, temp_avg_ff} << 3) - {4'd0, temp_avg_ff} + {4'd0, req_ch.reading};
      temp_new  = temp_sum[18:3];
      light_sum = ({4'd0, light_avg_ff[15:3]} << 3) - {4'd0, light_avg_ff[15:3]}
                  + {4'd0, req_ch.reading[15:3]};
      light_new = (light_sum >= LIGHT_AVG_LIMIT) ? LIGHT_AVG_MAX : light_sum[15:0];
   end

   // Only the selected mode's average moves.
   always_comb begin
      temp_avg_in  = temp_avg_ff;
      light_avg_in = light_avg_ff;
      data_in      = data_ff;
      if (accept) begin
         data_in.light = req_ch.light_mode;
         if (req_ch.light_mode) begin
            light_avg_in = light_new;
            data_in.avg  = light_new;
         end else begin
            temp_avg_in = temp_new;
            data_in.avg = temp_new;
         end
      end
   end

   // Holding register valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (upd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_avg_ff  <= TEMP_AVG_RESET;
         light_avg_ff <= LIGHT_AVG_RESET;
         valid_ff     <= 1'b0;
      end else begin
         temp_avg_ff  <= temp_avg_in;
         light_avg_ff <= light_avg_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign upd_valid = valid_ff;
   assign upd_data  = data_ff;

endmodule

FILE: rtl/sabd_rows.sv
// Digit conversion and LED bar row emitter with the result register.
`timescale 1ns / 1ps
module sabd_rows (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  upd_valid,
   output logic                  upd_ready,
   input  sabd_pkg::sabd_avg_type upd_data,
   sabd_rsp_if.source            rsp_ch
);
   import sabd_pkg::*;

   // Working item: average, mode, digits and the next row to send.
   logic             work_valid_ff, work_valid_in;
   sabd_avg_type     work_ff, work_in;
   sabd_digits_type  digits_ff, digits_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Result register.
   logic             out_valid_ff, out_valid_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [7:0]       out_bits_ff, out_bits_in;
   sabd_digits_type  out_digits_ff, out_digits_in;
   sabd_avg_type     out_avg_ff, out_avg_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             emit;
   logic             at_last;
   logic             load;
   sabd_digits_type  digits_new;
   logic [10:0]      dec_n;
   logic [23:0]      prod_tens;
   logic [21:0]      prod_hund;
   logic [7:0]       q_tens;
   logic [4:0]       q_hund;
   logic [9:0]       prod_frac;
   logic [10:0]      rem_units;
   logic [7:0]       rem_tens;
   logic [7:0]       row_bits;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign emit      = work_valid_ff && out_free;
   assign at_last   = (row_ff == LAST_ROW);
   assign upd_ready = !work_valid_ff || (emit && at_last);
   assign load      = upd_valid && upd_ready;

   // Decimal digits by reciprocal multiplication: n/10 = n*6554 >> 16 and
   // n/100 = n*1311 >> 17, both exact for the value range seen here.
   always_comb begin
      if (upd_data.light) begin
         dec_n = upd_data.avg[14:4];
      end else begin
         dec_n = {1'b0, upd_data.avg[15:6]};
      end
      prod_tens = {13'd0, dec_n} * 24'd6554;
      prod_hund = {11'd0, dec_n} * 22'd1311;
      q_tens    = prod_tens[23:16];
      q_hund    = prod_hund[21:17];
      prod_frac = {4'd0, upd_data.avg[5:0]} * 10'd10;
      rem_units = dec_n - ({3'd0, q_tens} << 3) - ({3'd0, q_tens} << 1);
      rem_tens  = q_tens - ({3'd0, q_hund} << 3) - ({3'd0, q_hund} << 1);
      if (upd_data.light) begin
         digits_new.first  = q_hund[3:0];
         digits_new.second = rem_tens[3:0];
         digits_new.third  = rem_units[3:0];
      end else begin
         digits_new.first  = q_tens[3:0];
         digits_new.second = rem_units[3:0];
         digits_new.third  = prod_frac[9:6];
      end
   end

   // One LED row: eight threshold compares against the average.
   always_comb begin
      logic [AVG_W-1:0] diff;
      row_bits = '0;
      for (int j = 0; j < 8; j++) begin
         diff        = bar_threshold(work_ff.light, {row_ff, 3'(j)}) - work_ff.avg;
         row_bits[j] = diff[AVG_W-1];
      end
   end

   // Working item control: load a new item when idle or when the last row leaves.
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      digits_in     = digits_ff;
      row_in        = row_ff;
      if (load) begin
         work_valid_in = 1'b1;
         work_in       = upd_data;
         digits_in     = digits_new;
         row_in        = '0;
      end else if (emit) begin
         work_valid_in = !at_last;
         row_in        = row_ff + 1'b1;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_row_in    = out_row_ff;
      out_bits_in   = out_bits_ff;
      out_digits_in = out_digits_ff;
      out_avg_in    = out_avg_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_row_in    = row_ff;
         out_bits_in   = row_bits;
         out_digits_in = digits_ff;
         out_avg_in    = work_ff;
         out_last_in   = at_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         row_ff        <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      digits_ff     <= digits_in;
      out_row_ff    <= out_row_in;
      out_bits_ff   <= out_bits_in;
      out_digits_ff <= out_digits_in;
      out_avg_ff    <= out_avg_in;
      out_last_ff   <= out_last_in;
   end

   // Result channel payload.
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.row_index     = out_row_ff;
   assign rsp_ch.row_bits      = out_bits_ff;
   assign rsp_ch.digit_first   = out_digits_ff.first;
   assign rsp_ch.digit_second  = out_digits_ff.second;
   assign rsp_ch.digit_third   = out_digits_ff.third;
   assign rsp_ch.digit_unit    = out_avg_ff.light ? GLYPH_LUX : GLYPH_CELSIUS;
   assign rsp_ch.colon_on      = !out_avg_ff.light;
   assign rsp_ch.average_value = out_avg_ff.avg;
   assign rsp_ch.last_row      = out_last_ff;

endmodule

FILE: rtl/sensor_average_bar_display_unit.sv
// Top level of the sensor average bar display.
//
// Readings enter on req_ch (light_mode selects temperature in 10.6 or light
// in 12.4 fixed point). Each item updates that mode's running average and
// produces ROWS result items on rsp_ch, one per LED bar row, all carrying the
// same display digits, unit glyph, colon flag and updated average; last_row
// marks the final row.
// A reading is registered in the update stage's holding register, then in
// the row emitter's working register, and its rows leave through the result
// register. The row emitter sends one row per cycle while the receiver keeps
// up. A reading may be accepted while the previous one's rows are still going
// out, so rows of consecutive readings follow without a gap.
// Reset sets the temperature average to 25 degrees, the light average to
// zero, and empties the pipeline.
// When the receiver stalls, the current row holds in the result register,
// the emitter waits, and req_ch.ready drops once the holding stage is full.
`timescale 1ns / 1ps
module sensor_average_bar_display_unit (
   input  logic       clock,
   input  logic       reset,
   sabd_req_if.sink   req_ch,
   sabd_rsp_if.source rsp_ch
);
   import sabd_pkg::*;

   logic         upd_valid;
   logic         upd_ready;
   sabd_avg_type upd_data;

   sabd_update u_update (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .upd_valid (upd_valid),
      .upd_ready (upd_ready),
      .upd_data  (upd_data)
   );

   sabd_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .upd_valid (upd_valid),
      .upd_ready (upd_ready),
      .upd_data  (upd_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: rtl/sabd_checker.sv
// Port-level checks of the sensor average bar display and their binding.
`timescale 1ns / 1ps
module sabd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_row_index,
   input logic [4:0]  rsp_digit_unit,
   input logic        rsp_colon_on,
   input logic [15:0] rsp_average_value,
   input logic        rsp_last_row
);
   import sabd_pkg::*;

   // A stalled result keeps its row and average.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
                                 && $stable(rsp_average_value))
      else $error("stalled result item changed");

   // Rows of one reading follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 4'd1
         && rsp_average_value == $past(rsp_average_value))
      else $error("row sequence broken within a reading");

   // The last-row flag marks exactly the final row number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_row == (rsp_row_index == LAST_ROW))
      else $error("last_row does not match row_index");

   // The colon and the unit glyph agree on the mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_colon_on && rsp_digit_unit == GLYPH_CELSIUS)
                    || (!rsp_colon_on && rsp_digit_unit == GLYPH_LUX))
      else $error("colon flag and unit glyph disagree");

endmodule

bind sensor_average_bar_display_unit sabd_checker u_sabd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_row_index     (rsp_ch.row_index),
   .rsp_digit_unit    (rsp_ch.digit_unit),
   .rsp_colon_on      (rsp_ch.colon_on),
   .rsp_average_value (rsp_ch.average_value),
   .rsp_last_row      (rsp_ch.last_row)
);

FILE: sim/tb_sensor_average_bar_display_unit.sv
// Self-checking testbench for the sensor average bar display unit.
`timescale 1ns / 1ps
module tb_sensor_average_bar_display_unit;
   import sabd_pkg::*;

   // Cycles without any accepted item before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles the receiver refuses results when the sender asks for a long stall.
   localparam int LONG_HOLD      = 90;
   localparam int RANDOM_ITEMS   = 420;
   localparam int DIRECTED_COUNT = 20;

   // One reading to send, with hand-computed display fields where they are obvious.
   typedef struct packed {
      logic        light;
      logic [15:0] reading;
      logic        golden;
      logic [15:0] g_avg;
      logic [3:0]  g_first;
      logic [3:0]  g_second;
      logic [3:0]  g_third;
   } probe_type;

   // One expected bar row result.
   typedef struct packed {
      logic [3:0]  index;
      logic [7:0]  bits;
      logic [3:0]  first;
      logic [3:0]  second;
      logic [3:0]  third;
      logic [4:0]  glyph;
      logic        colon;
      logic [15:0] avg;
      logic        last;
   } bar_row_type;

   // Directed readings: reset values, both extremes, the light clamp and the
   // wrapped temperature thresholds.
   localparam probe_type DIRECTED [DIRECTED_COUNT] = '{
      '{1'b0, 16'd1600,  1'b1, 16'd1600,  4'd2,  4'd5, 4'd0},
      '{1'b1, 16'd0,     1'b1, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'hFFFF,  1'b1, 16'd8191,  4'd5,  4'd1, 4'd1},
      '{1'b1, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'hFFFF,  1'b1, 16'd25599, 4'd15, 4'd9, 4'd9},
      '{1'b1, 16'hFFFF,  1'b1, 16'd25599, 4'd15, 4'd9, 4'd9},
      '{1'b0, 16'd0,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'd0,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'd0,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'd8,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'h8000,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'd7,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'd7,     1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'h5555,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b1, 16'hAAAA,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0},
      '{1'b0, 16'hFFFF,  1'b0, 16'd0,     4'd0,  4'd0, 4'd0}
   };

   logic      clock;
   logic      reset;
   probe_type offered;
   int        hold_requests = 0;

   sabd_req_if req_ch ();
   sabd_rsp_if rsp_ch ();

   sensor_average_bar_display_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predictor state and run statistics.
   logic [15:0] temp_average  = TEMP_AVG_RESET;
   logic [15:0] light_average = LIGHT_AVG_RESET;
   bar_row_type rows_due[$];
   int          mismatches    = 0;
   int          rows_checked  = 0;
   int          temp_readings = 0;
   int          light_readings = 0;
   int          clamp_hits    = 0;
   int          input_held    = 0;
   int          idle_cycles   = 0;

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns: row mismatch on %s: got %0d, expected %0d",
                  $time, field, got, want);
      end
   endtask

   // Fold one accepted reading into its running average and queue its bar rows.
   task automatic fold_reading(input logic light, input logic [15:0] x, input probe_type g);
      logic [18:0] wide;
      logic [16:0] lsum;
      logic [15:0] avg;
      logic [15:0] th;
      logic [15:0] diff;
      logic [7:0]  bits;
      logic [3:0]  first;
      logic [3:0]  second;
      logic [3:0]  third;
      int          whole;
      int          lux;
      int          id;
      bar_row_type row;
      if (!light) begin
         wide = ({3'b0, temp_average} * 19'd7 + {3'b0, x}) / 19'd8;
         temp_average = wide[15:0];
         avg = temp_average;
         whole = int'(avg >> 6);
         first = 4'(whole / 10);
         second = 4'(whole % 10);
         third = 4'((int'(avg[5:0]) * 10) >> 6);
         temp_readings++;
      end else begin
         lsum = {1'b0, light_average / 16'd8} * 17'd7 + {1'b0, x / 16'd8};
         if (int'(lsum) > int'(LIGHT_AVG_MAX)) begin
            lsum = {1'b0, LIGHT_AVG_MAX};
            clamp_hits++;
         end
         light_average = lsum[15:0];
         avg = light_average;
         lux = int'(avg >> 4);
         first = 4'(lux / 100);
         second = 4'((lux / 10) % 10);
         third = 4'(lux % 10);
         light_readings++;
      end
      // Hand-computed values replace the predicted display fields where given.
      if (g.golden) begin
         avg = g.g_avg;
         first = g.g_first;
         second = g.g_second;
         third = g.g_third;
      end
      for (int r = 0; r < ROWS; r++) begin
         for (int j = 0; j < 8; j++) begin
            id = r * 8 + j;
            if (light) begin
               th = 16'(320 * id);
            end else if (id < 50) begin
               th = 16'(128 * id);
            end else begin
               th = 16'(128 * (id - 60));
            end
            diff = th - avg;
            bits[j] = diff[15];
         end
         row.index = 4'(r);
         row.bits = bits;
         row.first = first;
         row.second = second;
         row.third = third;
         row.glyph = light ? GLYPH_LUX : GLYPH_CELSIUS;
         row.colon = !light;
         row.avg = avg;
         row.last = (r == ROWS - 1);
         rows_due.push_back(row);
      end
   endtask

   // Predict on accepted readings, compare accepted rows, and guard against hangs.
   always @(posedge clock) begin : check_rows
      bar_row_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            fold_reading(req_ch.light_mode, req_ch.reading, offered);
         end
         if (req_ch.valid && !req_ch.ready) begin
            input_held++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rows_due.size() == 0) begin
               report_mismatch("unexpected row index", rsp_ch.row_index, -1);
            end else begin
               want = rows_due.pop_front();
               rows_checked++;
               if (rsp_ch.row_index !== want.index)
                  report_mismatch("row_index", rsp_ch.row_index, want.index);
               if (rsp_ch.row_bits !== want.bits)
                  report_mismatch("row_bits", rsp_ch.row_bits, want.bits);
               if (rsp_ch.digit_first !== want.first)
                  report_mismatch("digit_first", rsp_ch.digit_first, want.first);
               if (rsp_ch.digit_second !== want.second)
                  report_mismatch("digit_second", rsp_ch.digit_second, want.second);
               if (rsp_ch.digit_third !== want.third)
                  report_mismatch("digit_third", rsp_ch.digit_third, want.third);
               if (rsp_ch.digit_unit !== want.glyph)
                  report_mismatch("digit_unit", rsp_ch.digit_unit, want.glyph);
               if (rsp_ch.colon_on !== want.colon)
                  report_mismatch("colon_on", rsp_ch.colon_on, want.colon);
               if (rsp_ch.average_value !== want.avg)
                  report_mismatch("average_value", rsp_ch.average_value, want.avg);
               if (rsp_ch.last_row !== want.last)
                  report_mismatch("last_row", rsp_ch.last_row, want.last);
            end
         end
         // Watchdog: any accepted item counts as progress.
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Watchdog: no item moved for %0d cycles, %0d rows outstanding.",
                        idle_cycles, rows_due.size());
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // Result receiver: changes its stall style at random intervals, and
   // refuses rows for a long stretch when the sender asks for it.
   initial begin : rsp_sink
      int style;
      int span;
      int phase;
      int hold_left;
      int hold_seen;
      rsp_ch.ready = 1'b0;
      style = 0;
      span = 0;
      phase = 0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (span == 0) begin
            style = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
         end
         span--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ch.ready <= (phase % 4 != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 6) != 0);
            endcase
         end
      end
   end

   // Present one reading and hold it until the block takes it.
   task automatic offer(input probe_type p);
      req_ch.valid <= 1'b1;
      req_ch.light_mode <= p.light;
      req_ch.reading <= p.reading;
      offered <= p;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // Stop sending and wait until every expected row has come back.
   task automatic drain_rows();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (rows_due.size() != 0);
   endtask

   // Stimulus: directed readings, then bursts that settle an average near a
   // chosen level, mixed with noise in either mode.
   initial begin : stimulus
      probe_type p;
      int        sent;
      int        burst;
      int        gap;
      int        level;
      logic      burst_light;
      bit        pressure_done;
      bit        pause_done;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.light_mode = 1'b0;
      req_ch.reading = 16'd0;
      offered = '0;
      pressure_done = 1'b0;
      pause_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, mostly back to back.
      foreach (DIRECTED[i]) begin
         offer(DIRECTED[i]);
         if ($urandom_range(0, 2) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      drain_rows();

      // Random part in bursts.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         burst_light = ($urandom_range(0, 1) == 1);
         case ($urandom_range(0, 5))
            0: level = 0;
            1: level = 65535;
            2: level = $urandom_range(0, 3200);
            default: level = $urandom_range(0, 65535);
         endcase
         // Long receiver stall while a long burst keeps coming.
         if (!pressure_done && sent >= 120) begin
            hold_requests <= hold_requests + 1;
            burst = 40;
            pressure_done = 1'b1;
         end
         for (int k = 0; k < burst; k++) begin
            p = '0;
            if ($urandom_range(0, 3) != 0) begin
               p.light = burst_light;
               p.reading = 16'(level + $urandom_range(0, 511) - 256);
            end else begin
               p.light = ($urandom_range(0, 1) == 1);
               p.reading = 16'($urandom_range(0, 65535));
            end
            offer(p);
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (!pause_done && sent >= 260) begin
            drain_rows();
            pause_done = 1'b1;
         end
      end

      // Let the last rows arrive, then a little longer for stray results.
      drain_rows();
      repeat (20) @(posedge clock);

      $display("Run covered %0d readings (%0d temperature, %0d light) and %0d bar rows.",
               temp_readings + light_readings, temp_readings, light_readings, rows_checked);
      $display("Light clamp reached %0d times; input held back for %0d cycles.",
               clamp_hits, input_held);
      if (mismatches == 0 && rows_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/sabd_pkg.sv
rtl/sabd_req_if.sv
rtl/sabd_update.sv
rtl/sabd_rows.sv
rtl/sensor_average_bar_display_unit.sv
rtl/sabd_checker.sv
sim/tb_sensor_average_bar_display_unit.sv
